// ----- src/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants that the base64 stream decoder modules share.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Result status codes
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_LEN_ERR  = 2'd2;
    localparam logic [1:0] ST_BAD_CHAR = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [7:0] NUL_CHAR = 8'h00;

    // Most results one character can cause
    localparam int MAX_RESULTS = 3;

    // Result queue
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = PTR_W + 1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] byte_count;
        logic        last_of_run;
    } b64d_item_t;

    // Results that one character pushes into the queue, item 0 first
    typedef struct packed {
        logic [1:0]                   num;
        b64d_item_t [MAX_RESULTS-1:0] item;
    } b64d_push_t;

endpackage

// ----- src/b64d_decode.sv -----
// ----------------------------------------------------------------------------
// b64d_decode
// Input register, message state and the per-character decode step.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_char,
    input  logic                strict_mode,
    input  logic                room,
    output b64d_pkg::b64d_push_t push
);
    import b64d_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;

    logic [1:0]  pos_reg,     pos_next;
    logic [17:0] partial_reg, partial_next;
    logic        await_reg,   await_next;
    logic        skip_reg,    skip_next;
    logic [15:0] cnt_reg,     cnt_next;

    logic        fire;
    logic [6:0]  sym;
    logic [5:0]  sym6;
    logic        is_sym;
    logic [15:0] cnt_p1, cnt_p2, cnt_p3;
    logic [23:0] word;
    logic [1:0]  num;
    b64d_item_t [MAX_RESULTS-1:0] items;

    // 0..63 for an alphabet symbol, 64 otherwise
    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            v = 7'd62;
        end else if (c == 8'h2f) begin
            v = 7'd63;
        end
        return v;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] n);
        logic [16:0] s;
        s = {1'b0, a} + 17'(n);
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    function automatic b64d_item_t data_item(input logic [7:0] b);
        b64d_item_t it;
        it.out_byte    = b;
        it.status      = ST_DATA;
        it.byte_count  = '0;
        it.last_of_run = 1'b0;
        return it;
    endfunction

    function automatic b64d_item_t status_item(input logic [1:0] st, input logic [15:0] n);
        b64d_item_t it;
        it.out_byte    = '0;
        it.status      = st;
        it.byte_count  = n;
        it.last_of_run = 1'b0;
        return it;
    endfunction

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    assign sym    = sym_value(in_char_reg);
    assign sym6   = sym[5:0];
    assign is_sym = !sym[6];
    assign cnt_p1 = sat_add(cnt_reg, 2'd1);
    assign cnt_p2 = sat_add(cnt_reg, 2'd2);
    assign cnt_p3 = sat_add(cnt_reg, 2'd3);
    assign word   = {partial_reg, sym6};

    always_comb begin
        pos_next     = pos_reg;
        partial_next = partial_reg;
        await_next   = await_reg;
        skip_next    = skip_reg;
        cnt_next     = cnt_reg;
        num          = 2'd0;
        items        = '0;

        if (skip_reg) begin
            if (in_char_reg == NUL_CHAR) begin
                pos_next     = '0;
                partial_next = '0;
                await_next   = 1'b0;
                skip_next    = 1'b0;
                cnt_next     = '0;
            end
        end else if (await_reg) begin
            if (in_char_reg == PAD_CHAR) begin
                cnt_next   = cnt_p1;
                items[0]   = data_item(partial_reg[11:4]);
                items[1]   = status_item(ST_OK, cnt_p1);
                num        = 2'd2;
                skip_next  = 1'b1;
                await_next = 1'b0;
            end else begin
                items[0] = status_item(ST_LEN_ERR, cnt_reg);
                num      = 2'd1;
                if (in_char_reg == NUL_CHAR) begin
                    pos_next     = '0;
                    partial_next = '0;
                    await_next   = 1'b0;
                    skip_next    = 1'b0;
                    cnt_next     = '0;
                end else begin
                    skip_next  = 1'b1;
                    await_next = 1'b0;
                end
            end
        end else if (in_char_reg == NUL_CHAR) begin
            items[0]     = status_item((pos_reg != 2'd0) ? ST_LEN_ERR : ST_OK, cnt_reg);
            num          = 2'd1;
            pos_next     = '0;
            partial_next = '0;
            await_next   = 1'b0;
            skip_next    = 1'b0;
            cnt_next     = '0;
        end else if (in_char_reg == PAD_CHAR) begin
            if (pos_reg < 2'd2) begin
                items[0]  = status_item(ST_LEN_ERR, cnt_reg);
                num       = 2'd1;
                skip_next = 1'b1;
            end else if (pos_reg == 2'd2) begin
                await_next = 1'b1;
            end else begin
                cnt_next  = cnt_p2;
                items[0]  = data_item(partial_reg[17:10]);
                items[1]  = data_item(partial_reg[9:2]);
                items[2]  = status_item(ST_OK, cnt_p2);
                num       = 2'd3;
                skip_next = 1'b1;
            end
        end else if (!is_sym) begin
            // lax mode drops the character without moving the group position
            if (strict_mode) begin
                items[0]  = status_item(ST_BAD_CHAR, cnt_reg);
                num       = 2'd1;
                skip_next = 1'b1;
            end
        end else if (pos_reg == 2'd3) begin
            cnt_next     = cnt_p3;
            items[0]     = data_item(word[23:16]);
            items[1]     = data_item(word[15:8]);
            items[2]     = data_item(word[7:0]);
            num          = 2'd3;
            partial_next = '0;
            pos_next     = '0;
        end else begin
            partial_next = {partial_reg[11:0], sym6};
            pos_next     = pos_reg + 2'd1;
        end

        unique case (num)
            2'd1:    items[0].last_of_run = 1'b1;
            2'd2:    items[1].last_of_run = 1'b1;
            2'd3:    items[2].last_of_run = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        push.num  = fire ? num : 2'd0;
        push.item = items;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            partial_reg  <= '0;
            await_reg    <= 1'b0;
            skip_reg     <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                pos_reg     <= pos_next;
                partial_reg <= partial_next;
                await_reg   <= await_next;
                skip_reg    <= skip_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_in_char;
        end
    end

    a_last_marks_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> push.item[push.num - 2'd1].last_of_run)
        else $error("last_of_run missing on final result of a request");

    a_await_at_pos2: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (pos_reg == 2'd2 && !skip_reg))
        else $error("second pad expected outside group position 2");

    a_skip_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && skip_reg) |-> (push.num == 2'd0))
        else $error("results pushed while skipping to terminator");

endmodule

// ----- src/b64d_out_fifo.sv -----
// ----------------------------------------------------------------------------
// b64d_out_fifo
// Result queue: takes up to three results a cycle, delivers one a cycle while m_ready is high.
// ----------------------------------------------------------------------------
module b64d_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64d_pkg::b64d_push_t push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output b64d_pkg::b64d_item_t head
);
    import b64d_pkg::*;

    b64d_item_t mem [OUT_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign m_valid    = (count_reg != '0);
    assign pop        = m_valid && m_ready;
    assign room       = (count_reg <= CNT_W'(OUT_DEPTH - MAX_RESULTS));
    assign head       = mem[rd_ptr_reg];
    assign count_next = count_reg + CNT_W'(push.num) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.num);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push.num) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push.item[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> (count_reg <= CNT_W'(OUT_DEPTH - MAX_RESULTS)))
        else $error("results pushed without queue room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue count out of range");

endmodule

// ----- src/base64_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character per request in, decoded bytes and
// one status result per message out.
// ----------------------------------------------------------------------------
// A character request is taken every cycle as long as the result queue has
// room for three results; each character produces zero to three results, and
// the result port delivers one per cycle while m_ready is high, so the
// sustained rate is one character per cycle for characters that yield at most
// one result and is bounded by the result port otherwise. A result passes
// through the input register, then the eight-entry result queue, before it
// reaches the result port. strict_mode is written through the cfg port,
// which is always ready, and must only change while the decoder is idle.
module base64_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_strict_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_status,
    output logic [15:0] m_byte_count,
    output logic        m_last_of_run
);
    import b64d_pkg::*;

    logic       strict_reg;
    logic       room;
    b64d_push_t push;
    b64d_item_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            strict_reg <= cfg_strict_mode;
        end
    end

    b64d_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .strict_mode (strict_reg),
        .room        (room),
        .push        (push)
    );

    b64d_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_byte    = head.out_byte;
    assign m_status      = head.status;
    assign m_byte_count  = head.byte_count;
    assign m_last_of_run = head.last_of_run;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_stream_decoder_core. It streams characters
// in, decodes them again in a scoreboard of its own, and compares every
// result field by field. The run covers a directed pass over the padding,
// terminator and invalid-character cases, then random encoded, broken and
// noise messages under several handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_CHARS   = 105;

    class b64_decode_scoreboard;
        localparam bit [6:0] SYM_NONE = 7'd64;

        bit         strict_mode;
        bit [1:0]   grp_pos;
        bit [17:0]  held_bits;
        bit         await_pad2;
        bit         skipping;
        bit [15:0]  msg_bytes;
        b64d_item_t expected_q[$];
        int         failures;

        function new();
            strict_mode = 1'b1;
            failures    = 0;
            clear_msg();
        endfunction

        function void clear_msg();
            grp_pos    = '0;
            held_bits  = '0;
            await_pad2 = 1'b0;
            skipping   = 1'b0;
            msg_bytes  = '0;
        endfunction

        function void add_bytes(int n);
            int sum;
            sum = int'(msg_bytes) + n;
            msg_bytes = (sum > 65535) ? 16'hffff : 16'(sum);
        endfunction

        // Alphabet value 0..63, SYM_NONE for anything else
        function bit [6:0] sym_of(bit [7:0] c);
            if (c >= 8'h41 && c <= 8'h5a) return 7'(c - 8'h41);
            if (c >= 8'h61 && c <= 8'h7a) return 7'(c - 8'h61 + 8'd26);
            if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
            if (c == 8'h2b) return 7'd62;
            if (c == 8'h2f) return 7'd63;
            return SYM_NONE;
        endfunction

        function b64d_item_t data_item(bit [7:0] b);
            b64d_item_t it;
            it.out_byte    = b;
            it.status      = ST_DATA;
            it.byte_count  = '0;
            it.last_of_run = 1'b0;
            return it;
        endfunction

        function b64d_item_t status_item(logic [1:0] st);
            b64d_item_t it;
            it.out_byte    = '0;
            it.status      = st;
            it.byte_count  = msg_bytes;
            it.last_of_run = 1'b0;
            return it;
        endfunction

        function void note_char(bit [7:0] c);
            b64d_item_t run[$];
            bit [6:0]   v;
            bit [23:0]  w;
            v = sym_of(c);
            if (skipping) begin
                if (c == NUL_CHAR) clear_msg();
            end else if (await_pad2) begin
                if (c == PAD_CHAR) begin
                    add_bytes(1);
                    run.push_back(data_item(held_bits[11:4]));
                    run.push_back(status_item(ST_OK));
                    skipping   = 1'b1;
                    await_pad2 = 1'b0;
                end else begin
                    run.push_back(status_item(ST_LEN_ERR));
                    if (c == NUL_CHAR) begin
                        clear_msg();
                    end else begin
                        skipping   = 1'b1;
                        await_pad2 = 1'b0;
                    end
                end
            end else if (c == NUL_CHAR) begin
                run.push_back(status_item(grp_pos != 0 ? ST_LEN_ERR : ST_OK));
                clear_msg();
            end else if (c == PAD_CHAR) begin
                if (grp_pos < 2) begin
                    run.push_back(status_item(ST_LEN_ERR));
                    skipping = 1'b1;
                end else if (grp_pos == 2) begin
                    await_pad2 = 1'b1;
                end else begin
                    add_bytes(2);
                    run.push_back(data_item(held_bits[17:10]));
                    run.push_back(data_item(held_bits[9:2]));
                    run.push_back(status_item(ST_OK));
                    skipping = 1'b1;
                end
            end else if (v == SYM_NONE) begin
                if (strict_mode) begin
                    run.push_back(status_item(ST_BAD_CHAR));
                    skipping = 1'b1;
                end
            end else if (grp_pos == 3) begin
                w = {held_bits, v[5:0]};
                add_bytes(3);
                run.push_back(data_item(w[23:16]));
                run.push_back(data_item(w[15:8]));
                run.push_back(data_item(w[7:0]));
                held_bits = '0;
                grp_pos   = '0;
            end else begin
                held_bits = {held_bits[11:0], v[5:0]};
                grp_pos   = grp_pos + 2'd1;
            end
            if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
            foreach (run[i]) expected_q.push_back(run[i]);
        endfunction

        function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                failures++;
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            end
        endfunction

        function void check_result(b64d_item_t got);
            b64d_item_t exp_it;
            if (expected_q.size() == 0) begin
                failures++;
                $error("result with nothing expected: out_byte %0h status %0d",
                       got.out_byte, got.status);
                return;
            end
            exp_it = expected_q.pop_front();
            cmp_field("out_byte", 16'(exp_it.out_byte), 16'(got.out_byte));
            cmp_field("status", 16'(exp_it.status), 16'(got.status));
            cmp_field("byte_count", exp_it.byte_count, got.byte_count);
            cmp_field("last_of_run", 16'(exp_it.last_of_run), 16'(got.last_of_run));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic        cfg_strict_mode = 1'b1;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_char       = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_status;
    logic [15:0] m_byte_count;
    logic        m_last_of_run;

    b64_decode_scoreboard sb = new();

    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    bit         hold_req     = 1'b0;
    int         hold_left    = 0;
    int         idle_cycles  = 0;
    int         chars_sent   = 0;
    logic [7:0] msg_q[$];

    base64_stream_decoder_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_strict_mode (cfg_strict_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_status        (m_status),
        .m_byte_count    (m_byte_count),
        .m_last_of_run   (m_last_of_run)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_result({m_out_byte, m_status, m_byte_count, m_last_of_run});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)
            || (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] enc_sym(bit [5:0] v);
        if (v < 26) return 8'h41 + 8'(v);
        if (v < 52) return 8'h61 + 8'(v) - 8'd26;
        if (v < 62) return 8'h30 + 8'(v) - 8'd52;
        return (v == 62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (sb.sym_of(c) != b64_decode_scoreboard::SYM_NONE || c == PAD_CHAR);
        return c;
    endfunction

    // In lax mode, sprinkle characters the decoder must skip
    function automatic void push_sym(bit [5:0] v);
        if (!sb.strict_mode && $urandom_range(99) < 15) msg_q.push_back(junk_char());
        msg_q.push_back(enc_sym(v));
    endfunction

    // Encode n random bytes into msg_q, with random unused bits before padding
    function automatic void build_encoded(int n);
        logic [23:0] w;
        int          i;
        for (i = 0; i + 3 <= n; i += 3) begin
            w = 24'($urandom);
            push_sym(w[23:18]);
            push_sym(w[17:12]);
            push_sym(w[11:6]);
            push_sym(w[5:0]);
        end
        if (n - i == 1) begin
            w = 24'($urandom);
            push_sym(w[23:18]);
            push_sym({w[17:16], 4'($urandom_range(15))});
            msg_q.push_back(PAD_CHAR);
            msg_q.push_back(PAD_CHAR);
        end else if (n - i == 2) begin
            w = 24'($urandom);
            push_sym(w[23:18]);
            push_sym(w[17:12]);
            push_sym({w[11:8], 2'($urandom_range(3))});
            msg_q.push_back(PAD_CHAR);
        end
        // Trailing characters after padding must be ignored
        if (n % 3 != 0 && $urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= c;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_char(c);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_random_message();
        int kind;
        int n;
        kind = $urandom_range(99);
        msg_q.delete();
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 10);
        if (kind < 80) build_encoded(n);
        if (kind >= 65 && kind < 80) begin
            // Break an otherwise valid message
            case ($urandom_range(2))
                0: if (msg_q.size() > 0) begin
                    n = $urandom_range(msg_q.size() - 1);
                    while (msg_q.size() > n) void'(msg_q.pop_back());
                end
                1: msg_q.insert($urandom_range(msg_q.size()), PAD_CHAR);
                default: if (msg_q.size() > 0)
                    msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(1, 255));
            endcase
        end else if (kind >= 80) begin
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(255)));
        end
        msg_q.push_back(NUL_CHAR);
        foreach (msg_q[i]) send_char(msg_q[i]);
    endtask

    // Hold until every expected result is out and the pipeline has settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_strict(input bit v);
        cfg_valid       <= 1'b1;
        cfg_strict_mode <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.strict_mode = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int start;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pass, strict mode out of reset
        send_text("/+Az");
        send_char(NUL_CHAR);
        send_text("=");
        send_char(NUL_CHAR);
        send_text("Q=x");
        send_char(NUL_CHAR);
        send_text("QQ==");
        send_char(NUL_CHAR);
        send_text("QQ=A");
        send_char(NUL_CHAR);
        send_text("QUI=");
        send_char(NUL_CHAR);
        send_char(8'hff);
        send_char(NUL_CHAR);
        wait_idle();
        write_strict(1'b0);
        send_text("Q");
        send_char(8'h80);
        send_text("U");
        send_char(NUL_CHAR);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            write_strict(ph % 2 == 0);
            // Back up the result queue so the input stalls
            if (ph == 0) hold_req = 1'b1;
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS) send_random_message();
            wait_idle();
        end

        if (sb.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
